// ===== hw/rtl/mesh_vertex_normal_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Mesh vertex normal engine assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MESH_VERTEX_NORMAL_ENGINE_DEFINES_SVH
`define MESH_VERTEX_NORMAL_ENGINE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication on clk, disabled in reset
`define MVN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication on clk, disabled in reset
`define MVN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MVN_ASSERT_IMPL(lbl, ante, cons, msg)
`define MVN_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/mvn_pkg.sv =====
// ----------------------------------------------------------------------------
// Mesh vertex normal engine package
// Shared defaults, command codes, sum limit and the normalizer status type.
// ----------------------------------------------------------------------------
package mvn_pkg;

  localparam int DEF_MAX_VERTICES = 4096;
  localparam int DEF_MAX_FACES    = 4096;
  localparam int DEF_COORD_WIDTH  = 24;

  localparam int IDX_W    = 12;
  localparam int CNT_W    = 13;
  localparam int NRM_W    = 16;
  localparam int SUM_W    = 64;
  localparam int OUT_BITS = 74;
  localparam int OUT_W    = 80;

  localparam logic [1:0] CMD_WRITE_VERTEX = 2'd0;
  localparam logic [1:0] CMD_WRITE_FACE   = 2'd1;
  localparam logic [1:0] CMD_QUERY        = 2'd2;

  localparam logic signed [SUM_W-1:0] SUM_LIMIT = 64'sd1 <<< 62;

  typedef struct packed {
    logic busy;
    logic done;
  } norm_stat_t;

endpackage

// ===== hw/rtl/mesh_vertex_normal_engine.sv =====
// ----------------------------------------------------------------------------
// Mesh vertex normal engine
// Stores a triangle mesh and answers vertex queries with the unit normal
// averaged over all faces that share the vertex.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake            | Payload
// s_*     | in  | s_tvalid/s_tready    | tuser command, tdata slot/coords/corners
// cfg_*   | in  | cfg_valid/cfg_ready  | cfg_data face_count
// m_*     | out | m_tvalid/m_tready    | tdata id, normal, shared count, isolated
//
// A query scans the face memory one entry per cycle while no shared face is
// found; each shared face costs three vertex memory reads and six passes of
// one multiplier, and the normalizer iterates root and division bit by bit.
// Reset clears control only; memories hold garbage until written. A finished
// result waits in the output register while writes go on; a second query
// stalls at its end until that is taken.
// ----------------------------------------------------------------------------
`include "mesh_vertex_normal_engine_defines.svh"

module mesh_vertex_normal_engine #(
  parameter int MAX_VERTICES = mvn_pkg::DEF_MAX_VERTICES,
  parameter int MAX_FACES    = mvn_pkg::DEF_MAX_FACES,
  parameter int COORD_WIDTH  = mvn_pkg::DEF_COORD_WIDTH,
  parameter int IN_W         = ((48 + 3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // command
  input  logic [1:0]                  s_tuser,
  // slot_index, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
  input  logic [IN_W-1:0]             s_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mvn_pkg::CNT_W-1:0]   cfg_data,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // vertex_id, normal_x, normal_y, normal_z, shared_faces, isolated
  output logic [mvn_pkg::OUT_W-1:0]   m_tdata
);

  localparam int CW  = COORD_WIDTH;
  localparam int VA  = $clog2(MAX_VERTICES);
  localparam int FA  = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int FCW = $clog2(MAX_FACES + 1);
  localparam int DW  = (CW > 24) ? 25 : CW + 1;
  localparam int DSH = (CW > 24) ? CW - 24 : 0;
  localparam int PW  = 2 * DW;
  localparam int IW  = mvn_pkg::IDX_W;
  localparam int CB  = IW + 3 * CW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FACE   = 4'd1;
  localparam logic [3:0] S_V0     = 4'd2;
  localparam logic [3:0] S_V1     = 4'd3;
  localparam logic [3:0] S_V2     = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_NSTART = 4'd6;
  localparam logic [3:0] S_NWAIT  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  // input fields
  logic [1:0]    in_cmd;
  logic [IW-1:0] in_slot, in_ca, in_cb, in_cc;
  logic [CW-1:0] in_x, in_y, in_z;
  assign in_cmd  = s_tuser;
  assign in_slot = s_tdata[IW-1:0];
  assign in_x    = s_tdata[IW +: CW];
  assign in_y    = s_tdata[IW+CW +: CW];
  assign in_z    = s_tdata[IW+2*CW +: CW];
  assign in_ca   = s_tdata[CB +: IW];
  assign in_cb   = s_tdata[CB+IW +: IW];
  assign in_cc   = s_tdata[CB+2*IW +: IW];

  // memories
  logic [3*CW-1:0] vmem [MAX_VERTICES];
  logic [3*IW-1:0] fmem [MAX_FACES];
  logic [3*CW-1:0] vrd;
  logic [3*IW-1:0] frd;
  logic [31:0]     va_wide;
  logic [31:0]     vwa_wide;
  logic [31:0]     fwa_wide;
  logic [FA-1:0]   far;
  logic            vok;

  // control and datapath registers
  logic [3:0]           state;
  logic [mvn_pkg::CNT_W-1:0] face_count;
  logic [IW-1:0]        qslot;
  logic [FCW-1:0]       limit;
  logic [FCW-1:0]       j;
  logic [FCW-1:0]       shared;
  logic [IW-1:0]        c1, c2;
  logic signed [CW-1:0] p0 [3];
  logic signed [CW-1:0] p1 [3];
  logic signed [DW-1:0] da [3];
  logic signed [DW-1:0] db [3];
  logic [2:0]           mstep;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] comp;
  logic signed [mvn_pkg::SUM_W-1:0] sum [3];
  logic                 norm_start;
  logic                 iso;
  logic                 in_acc;

  logic [FCW-1:0]       j_inc;
  logic                 fmatch;
  logic signed [CW-1:0] p2 [3];
  logic signed [CW:0]   d_a [3];
  logic signed [CW:0]   d_b [3];
  logic signed [CW:0]   d_as [3];
  logic signed [CW:0]   d_bs [3];
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [mvn_pkg::SUM_W-1:0] sadd;
  logic signed [mvn_pkg::SUM_W-1:0] ssat;
  logic [1:0]           sk;
  logic [31:0]          lim_w;
  logic [31:0]          shared_w;
  logic [mvn_pkg::NRM_W-1:0] nx, ny, nz;
  mvn_pkg::norm_stat_t  nstat;

  assign in_acc    = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign j_inc     = j + 1'b1;
  assign fmatch    = (frd[IW-1:0] == qslot) || (frd[2*IW-1:IW] == qslot) ||
                     (frd[3*IW-1:2*IW] == qslot);
  assign vwa_wide  = 32'(in_slot);
  assign fwa_wide  = 32'(in_slot);
  assign lim_w     = (32'(face_count) > MAX_FACES) ? 32'(MAX_FACES) : 32'(face_count);

  // load the face count register from the config channel
  always_ff @(posedge clk) begin
    if (rst) begin
      face_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      face_count <= cfg_data;
    end
  end

  // select next face and vertex read addresses
  always_comb begin
    far     = j[FA-1:0];
    va_wide = 32'(frd[IW-1:0]);
    case (state)
      S_IDLE: far = '0;
      S_FACE: begin
        if (!fmatch) far = j_inc[FA-1:0];
      end
      S_V0:   va_wide = 32'(c1);
      S_V1:   va_wide = 32'(c2);
      S_MUL: begin
        if (mstep == 3'd6) far = j_inc[FA-1:0];
      end
      default: ;
    endcase
  end

  // write and read the vertex memory
  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == mvn_pkg::CMD_WRITE_VERTEX && vwa_wide < MAX_VERTICES) begin
      vmem[vwa_wide[VA-1:0]] <= {in_z, in_y, in_x};
    end
    vrd <= vmem[va_wide[VA-1:0]];
    vok <= (va_wide < MAX_VERTICES);
  end

  // write and read the face memory
  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == mvn_pkg::CMD_WRITE_FACE && fwa_wide < MAX_FACES) begin
      fmem[fwa_wide[FA-1:0]] <= {in_cc, in_cb, in_ca};
    end
    frd <= fmem[far];
  end

  // form edge differences from the three corners
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p2[i]   = vok ? vrd[i*CW +: CW] : '0;
      d_a[i]  = {p0[i][CW-1], p0[i]} - {p2[i][CW-1], p2[i]};
      d_b[i]  = {p2[i][CW-1], p2[i]} - {p1[i][CW-1], p1[i]};
      d_as[i] = d_a[i] >>> DSH;
      d_bs[i] = d_b[i] >>> DSH;
    end
  end

  // pick multiplier operands for each cross product term
  always_comb begin
    case (mstep)
      3'd0:    begin mul_a = da[1]; mul_b = db[2]; end
      3'd1:    begin mul_a = da[2]; mul_b = db[1]; end
      3'd2:    begin mul_a = da[2]; mul_b = db[0]; end
      3'd3:    begin mul_a = da[0]; mul_b = db[2]; end
      3'd4:    begin mul_a = da[0]; mul_b = db[1]; end
      default: begin mul_a = da[1]; mul_b = db[0]; end
    endcase
  end

  // saturating add of one finished component
  always_comb begin
    sk   = 2'((mstep - 3'd2) >> 1);
    sadd = sum[sk] + mvn_pkg::SUM_W'(comp) - mvn_pkg::SUM_W'(prod);
    if (sadd > mvn_pkg::SUM_LIMIT) begin
      ssat = mvn_pkg::SUM_LIMIT;
    end else if (sadd < -mvn_pkg::SUM_LIMIT) begin
      ssat = -mvn_pkg::SUM_LIMIT;
    end else begin
      ssat = sadd;
    end
  end

  // advance the query sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      norm_start <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      norm_start <= 1'b0;
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc && in_cmd == mvn_pkg::CMD_QUERY) begin
            qslot  <= in_slot;
            limit  <= lim_w[FCW-1:0];
            j      <= '0;
            shared <= '0;
            for (int i = 0; i < 3; i++) sum[i] <= '0;
            state  <= (lim_w == 32'd0) ? S_NSTART : S_FACE;
          end
        end
        S_FACE: begin
          if (fmatch) begin
            c1    <= frd[2*IW-1:IW];
            c2    <= frd[3*IW-1:2*IW];
            state <= S_V0;
          end else begin
            j     <= j_inc;
            state <= (j_inc == limit) ? S_NSTART : S_FACE;
          end
        end
        S_V0: begin
          for (int i = 0; i < 3; i++) p0[i] <= vok ? vrd[i*CW +: CW] : '0;
          state <= S_V1;
        end
        S_V1: begin
          for (int i = 0; i < 3; i++) p1[i] <= vok ? vrd[i*CW +: CW] : '0;
          state <= S_V2;
        end
        S_V2: begin
          for (int i = 0; i < 3; i++) begin
            da[i] <= d_as[i][DW-1:0];
            db[i] <= d_bs[i][DW-1:0];
          end
          mstep <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (mstep != 3'd6) prod <= mul_a * mul_b;
          if (mstep == 3'd1 || mstep == 3'd3 || mstep == 3'd5) comp <= prod;
          if (mstep == 3'd2 || mstep == 3'd4 || mstep == 3'd6) sum[sk] <= ssat;
          if (mstep == 3'd6) begin
            shared <= shared + 1'b1;
            j      <= j_inc;
            state  <= (j_inc == limit) ? S_NSTART : S_FACE;
          end else begin
            mstep <= mstep + 3'd1;
          end
        end
        S_NSTART: begin
          if (shared == '0) begin
            iso   <= 1'b1;
            state <= S_DONE;
          end else begin
            iso        <= 1'b0;
            norm_start <= 1'b1;
            state      <= S_NWAIT;
          end
        end
        S_NWAIT: begin
          if (nstat.done) state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= mvn_pkg::OUT_W'({iso, shared_w[mvn_pkg::CNT_W-1:0],
                                          iso ? 16'd0 : nz, iso ? 16'd0 : ny,
                                          iso ? 16'd0 : nx, qslot});
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign shared_w = 32'(shared);

  mvn_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .sum_x (sum[0]),
    .sum_y (sum[1]),
    .sum_z (sum[2]),
    .nx    (nx),
    .ny    (ny),
    .nz    (nz),
    .stat  (nstat)
  );

  `MVN_ASSERT_IMPL(a_norm_start_shared, norm_start, shared != '0, "start without shared face")
  `MVN_ASSERT_IMPL(a_scan_bound, state == S_FACE, (j < limit) && (shared <= j), "scan out of range")
  `MVN_ASSERT_IMPL(a_out_from_done, $rose(m_tvalid), $past(state) == S_DONE, "result outside done")
  `MVN_ASSERT_NEXT(a_norm_busy, norm_start, nstat.busy || nstat.done, "normalizer ignored start")

endmodule

// ===== hw/rtl/mvn_norm.sv =====
// ----------------------------------------------------------------------------
// Mesh vertex normal normalizer
// Scales a summed vector to unit length in Q1.15 with a shared multiplier,
// a bit-serial square root and a restoring divider, and negates it.
// ----------------------------------------------------------------------------
module mvn_norm (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic signed [mvn_pkg::SUM_W-1:0]        sum_x,
  input  logic signed [mvn_pkg::SUM_W-1:0]        sum_y,
  input  logic signed [mvn_pkg::SUM_W-1:0]        sum_z,
  output logic        [mvn_pkg::NRM_W-1:0]        nx,
  output logic        [mvn_pkg::NRM_W-1:0]        ny,
  output logic        [mvn_pkg::NRM_W-1:0]        nz,
  output mvn_pkg::norm_stat_t                     stat
);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_LOAD  = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;

  logic [2:0]  state;
  logic [62:0] mag [3];
  logic [2:0]  neg;
  logic [1:0]  k;
  logic [5:0]  cnt;
  logic [59:0] prod;
  logic [63:0] sq;
  logic [63:0] rn;
  logic [63:0] rr;
  logic [63:0] rbit;
  logic [31:0] len;
  logic [45:0] num;
  logic [32:0] rem;
  logic        done;

  logic [63:0] rt;
  logic [32:0] rem_sh;
  logic [15:0] qv;
  logic [62:0] ax, ay, az;

  // magnitudes of the incoming sum
  assign ax = sum_x[63] ? 63'(-sum_x) : sum_x[62:0];
  assign ay = sum_y[63] ? 63'(-sum_y) : sum_y[62:0];
  assign az = sum_z[63] ? 63'(-sum_z) : sum_z[62:0];

  assign rt     = rr + rbit;
  assign rem_sh = {rem[31:0], num[45]};

  // saturate and negate the finished quotient
  always_comb begin
    if (neg[k]) begin
      qv = (num > 46'd32767) ? 16'h7FFF : num[15:0];
    end else begin
      qv = (num > 46'd32768) ? 16'h8000 : 16'(~num[15:0] + 16'd1);
    end
  end

  // sequence shift, squares, root and three divisions
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
      k     <= '0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        N_IDLE: begin
          if (start) begin
            mag[0] <= ax;
            mag[1] <= ay;
            mag[2] <= az;
            neg    <= {sum_z[63], sum_y[63], sum_x[63]};
            if ((ax | ay | az) == '0) begin
              nx   <= '0;
              ny   <= '0;
              nz   <= '0;
              done <= 1'b1;
            end else begin
              state <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          if ((mag[0][62:30] | mag[1][62:30] | mag[2][62:30]) != '0) begin
            mag[0] <= mag[0] >> 1;
            mag[1] <= mag[1] >> 1;
            mag[2] <= mag[2] >> 1;
          end else begin
            state <= N_SQ;
            cnt   <= '0;
            sq    <= '0;
          end
        end
        N_SQ: begin
          if (cnt < 6'd3) begin
            prod <= mag[cnt[1:0]][29:0] * mag[cnt[1:0]][29:0];
          end
          if (cnt != 6'd0) begin
            sq <= sq + 64'(prod);
          end
          if (cnt == 6'd3) begin
            state <= N_SQRT;
            cnt   <= '0;
            rn    <= sq + 64'(prod);
            rr    <= '0;
            rbit  <= 64'd1 << 62;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        N_SQRT: begin
          if (rn >= rt) begin
            rn <= rn - rt;
            rr <= (rr >> 1) + rbit;
          end else begin
            rr <= rr >> 1;
          end
          rbit <= rbit >> 2;
          if (cnt == 6'd31) begin
            state <= N_LOAD;
            k     <= '0;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        N_LOAD: begin
          if (k == 2'd0) begin
            len <= (rr == '0) ? 32'd1 : rr[31:0];
            num <= {1'b0, mag[0][29:0], 15'd0} + 46'(((rr == '0) ? 32'd1 : rr[31:0]) >> 1);
          end else begin
            num <= {1'b0, mag[k][29:0], 15'd0} + 46'(len >> 1);
          end
          rem   <= '0;
          cnt   <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          if (cnt == 6'd46) begin
            case (k)
              2'd0:    nx <= qv;
              2'd1:    ny <= qv;
              default: nz <= qv;
            endcase
            if (k == 2'd2) begin
              state <= N_IDLE;
              done  <= 1'b1;
            end else begin
              k     <= k + 2'd1;
              state <= N_LOAD;
            end
          end else begin
            if (rem_sh >= {1'b0, len}) begin
              rem <= rem_sh - {1'b0, len};
              num <= {num[44:0], 1'b1};
            end else begin
              rem <= rem_sh;
              num <= {num[44:0], 1'b0};
            end
            cnt <= cnt + 6'd1;
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  assign stat.busy = (state != N_IDLE);
  assign stat.done = done;

endmodule

// ===== test/tb_mesh_vertex_normal_engine.sv =====
// ----------------------------------------------------------------------------
// Mesh vertex normal engine testbench
// Preloads a small vertex and face set, then runs directed and random
// writes and queries under several idle and stall patterns. A scoreboard
// predicts every query result and compares it field by field.
// ----------------------------------------------------------------------------
module tb_mesh_vertex_normal_engine;

  localparam int IN_W      = 120;
  localparam int NV        = 4096;
  localparam int NF        = 4096;
  localparam int PRE_V     = 16;
  localparam int PRE_F     = 32;
  localparam int CYC_LIMIT = 3000000;
  localparam logic [1:0] CMD_NOP = 2'd3;

  typedef struct packed {
    logic [11:0] vertex_id;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic [12:0] shared;
    logic        isolated;
  } normal_res_t;

  // Mesh mirror and queue of pending vertex normals
  class normal_scoreboard;
    longint vx[NV];
    longint vy[NV];
    longint vz[NV];
    logic [11:0] fa[NF];
    logic [11:0] fb[NF];
    logic [11:0] fc[NF];
    int unsigned face_count;
    normal_res_t pending_normals[$];
    int errors;
    int queries;
    int isolated_seen;

    function longint unsigned isqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint sat(longint s);
      if (s > 64'sd4611686018427387904) return 64'sd4611686018427387904;
      if (s < -64'sd4611686018427387904) return -64'sd4611686018427387904;
      return s;
    endfunction

    function normal_res_t vertex_normal(logic [11:0] slot);
      normal_res_t r;
      longint sum[3], p0[3], p1[3], p2[3], a[3], b[3];
      longint unsigned mag[3], maxm, sq, len, q;
      bit neg[3];
      int unsigned lim, shared;
      logic [15:0] nrm[3];
      lim = (face_count > NF) ? NF : face_count;
      shared = 0;
      for (int k = 0; k < 3; k++) begin
        sum[k] = 0;
        nrm[k] = '0;
      end
      for (int j = 0; j < lim; j++) begin
        if (fa[j] == slot || fb[j] == slot || fc[j] == slot) begin
          p0 = '{vx[fa[j]], vy[fa[j]], vz[fa[j]]};
          p1 = '{vx[fb[j]], vy[fb[j]], vz[fb[j]]};
          p2 = '{vx[fc[j]], vy[fc[j]], vz[fc[j]]};
          for (int k = 0; k < 3; k++) begin
            a[k] = p0[k] - p2[k];
            b[k] = p2[k] - p1[k];
          end
          sum[0] = sat(sum[0] + a[1] * b[2] - a[2] * b[1]);
          sum[1] = sat(sum[1] + a[2] * b[0] - a[0] * b[2]);
          sum[2] = sat(sum[2] + a[0] * b[1] - a[1] * b[0]);
          shared++;
        end
      end
      if (shared != 0) begin
        maxm = 0;
        for (int k = 0; k < 3; k++) begin
          neg[k] = sum[k] < 0;
          mag[k] = neg[k] ? -sum[k] : sum[k];
          if (mag[k] > maxm) maxm = mag[k];
        end
        if (maxm != 0) begin
          // scale down together until every magnitude fits 30 bits
          while (maxm >= (64'd1 << 30)) begin
            maxm = maxm >> 1;
            for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
          end
          sq = 0;
          for (int k = 0; k < 3; k++) sq += mag[k] * mag[k];
          len = isqrt(sq);
          if (len == 0) len = 1;
          for (int k = 0; k < 3; k++) begin
            q = (mag[k] * 32768 + len / 2) / len;
            // output points against the summed cross product
            if (neg[k]) nrm[k] = (q > 32767) ? 16'h7FFF : q[15:0];
            else nrm[k] = (q > 32768) ? 16'h8000 : -q[15:0];
          end
        end
      end
      r.vertex_id = slot;
      r.nx = nrm[0];
      r.ny = nrm[1];
      r.nz = nrm[2];
      r.shared = shared[12:0];
      r.isolated = (shared == 0);
      return r;
    endfunction

    function void note_input(logic [1:0] cmd, logic [IN_W-1:0] d);
      logic [11:0] slot;
      slot = d[11:0];
      case (cmd)
        mvn_pkg::CMD_WRITE_VERTEX: begin
          vx[slot] = longint'($signed(d[35:12]));
          vy[slot] = longint'($signed(d[59:36]));
          vz[slot] = longint'($signed(d[83:60]));
        end
        mvn_pkg::CMD_WRITE_FACE: begin
          fa[slot] = d[95:84];
          fb[slot] = d[107:96];
          fc[slot] = d[119:108];
        end
        mvn_pkg::CMD_QUERY:
          pending_normals.insert(pending_normals.size(), vertex_normal(slot));
        default: ;
      endcase
    endfunction

    function void check_result(logic [mvn_pkg::OUT_W-1:0] d);
      normal_res_t e;
      if (pending_normals.size() == 0) begin
        $error("result with no query waiting: %0h", d);
        errors++;
        return;
      end
      e = pending_normals.pop_front();
      queries++;
      if (e.isolated) isolated_seen++;
      if (d[11:0] !== e.vertex_id) begin
        $error("vertex_id exp %0h got %0h", e.vertex_id, d[11:0]); errors++;
      end
      if (d[27:12] !== e.nx) begin
        $error("normal_x exp %0h got %0h", e.nx, d[27:12]); errors++;
      end
      if (d[43:28] !== e.ny) begin
        $error("normal_y exp %0h got %0h", e.ny, d[43:28]); errors++;
      end
      if (d[59:44] !== e.nz) begin
        $error("normal_z exp %0h got %0h", e.nz, d[59:44]); errors++;
      end
      if (d[72:60] !== e.shared) begin
        $error("shared_faces exp %0h got %0h", e.shared, d[72:60]); errors++;
      end
      if (d[73] !== e.isolated) begin
        $error("isolated exp %0h got %0h", e.isolated, d[73]); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [1:0] s_tuser = '0;
  logic [IN_W-1:0] s_tdata = '0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [mvn_pkg::CNT_W-1:0] cfg_data = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [mvn_pkg::OUT_W-1:0] m_tdata;

  normal_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;

  mesh_vertex_normal_engine i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Check results and drive backpressure, with an optional long hold-off
  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_result(m_tdata);
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= 3000;
      m_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 0;
    end else if (rst) begin
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [IN_W-1:0] pack_in(logic [11:0] slot, logic [23:0] x,
      logic [23:0] y, logic [23:0] z, logic [11:0] a, logic [11:0] b, logic [11:0] c);
    return {c, b, a, z, y, x, slot};
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send(logic [1:0] cmd, logic [IN_W-1:0] d);
    s_tuser <= cmd;
    s_tdata <= d;
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    sb.note_input(cmd, d);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending_normals.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_face_count(logic [mvn_pkg::CNT_W-1:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.face_count = v;
  endtask

  function automatic logic [11:0] pick_vertex();
    return ($urandom_range(9) < 8) ? 12'($urandom_range(15)) : 12'($urandom);
  endfunction

  task automatic send_query(logic [11:0] v);
    send(mvn_pkg::CMD_QUERY, pack_in(v, 24'($urandom), 24'($urandom), 24'($urandom),
         12'($urandom), 12'($urandom), 12'($urandom)));
  endtask

  // One random item: writes mostly into the small active mesh, queries, stray codes
  task automatic send_random();
    int r;
    r = $urandom_range(99);
    if (r < 30)
      send(mvn_pkg::CMD_WRITE_VERTEX, pack_in(pick_vertex(), 24'($urandom),
           24'($urandom), 24'($urandom), 12'($urandom), 12'($urandom), 12'($urandom)));
    else if (r < 60)
      send(mvn_pkg::CMD_WRITE_FACE, pack_in(($urandom_range(3) == 0) ? 12'($urandom)
           : 12'($urandom_range(PRE_F - 1)), 24'($urandom), 24'($urandom),
           24'($urandom), 12'($urandom_range(PRE_V - 1)),
           12'($urandom_range(PRE_V - 1)), 12'($urandom_range(PRE_V - 1))));
    else if (r < 95)
      send_query(pick_vertex());
    else
      send(CMD_NOP, pack_in(12'($urandom), 24'($urandom), 24'($urandom),
           24'($urandom), 12'($urandom), 12'($urandom), 12'($urandom)));
  endtask

  initial begin
    logic [23:0] cx;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Fill the active vertices and faces so no query reads an unwritten entry
    for (int i = 0; i < PRE_V; i++) begin
      cx = (i % 7 == 0) ? 24'h7FFFFF : (i % 7 == 1) ? 24'h800000 : 24'($urandom);
      send(mvn_pkg::CMD_WRITE_VERTEX, pack_in(12'(i), cx, 24'($urandom),
           24'($urandom), '0, '0, '0));
    end
    for (int i = 0; i < PRE_F; i++)
      send(mvn_pkg::CMD_WRITE_FACE, pack_in(12'(i), '0, '0, '0,
           12'($urandom_range(PRE_V - 1)), 12'($urandom_range(PRE_V - 1)),
           12'($urandom_range(PRE_V - 1))));

    // Directed: empty mesh, extremes, degenerate face, unused code
    sb.face_count = 0;
    send_query(12'd0);
    send_query(12'd4095);
    set_face_count(13'd4);
    send(mvn_pkg::CMD_WRITE_VERTEX, pack_in(12'd20, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
         '0, '0, '0));
    send(mvn_pkg::CMD_WRITE_VERTEX, pack_in(12'd21, 24'h800000, 24'h800000, 24'h7FFFFF,
         '0, '0, '0));
    send(mvn_pkg::CMD_WRITE_VERTEX, pack_in(12'd4095, 24'h800000, 24'h7FFFFF, 24'h800000,
         '0, '0, '0));
    send(mvn_pkg::CMD_WRITE_FACE, pack_in(12'd0, '0, '0, '0, 12'd20, 12'd21, 12'd4095));
    send(mvn_pkg::CMD_WRITE_FACE, pack_in(12'd1, '0, '0, '0, 12'd4095, 12'd20, 12'd21));
    send(mvn_pkg::CMD_WRITE_FACE, pack_in(12'd2, '0, '0, '0, 12'd5, 12'd5, 12'd5));
    send(mvn_pkg::CMD_WRITE_FACE, pack_in(12'd3, '0, '0, '0, 12'd0, 12'd4095, 12'd5));
    send_query(12'd20);
    send_query(12'd4095);
    send_query(12'd5);
    send_query(12'd3000);
    send(CMD_NOP, pack_in('1, '1, '1, '1, '1, '1, '1));
    send_query(12'd0);

    // Random phases under each idle pattern
    for (int ph = 0; ph < 4; ph++) begin
      set_face_count(13'($urandom_range(1, PRE_F)));
      send_idle_pct = (ph == 1) ? 61 : (ph == 3) ? 9 : 0;
      recv_stall_pct = (ph == 2) ? 61 : (ph == 3) ? 9 : 0;
      repeat (9) send_random();
      if (ph == 1) drain();
    end

    // Long receiver hold-off while queries keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_token <= hold_token + 1;
    repeat (8) send_query(pick_vertex());
    drain();

    repeat (300) @(posedge clk);
    $display("Checked %0d vertex normal queries (%0d isolated) over face counts 0..%0d",
             sb.queries, sb.isolated_seen, PRE_F);
    if (sb.errors == 0 && sb.pending_normals.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
